/* hw/rtl/fsc_pkg.sv */
// ----------------------------------------------------------------------------
// fsc_pkg
// Types, codes and the per-character judge function of the format checker.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int unsigned CNT_W      = 8;
  localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;
  localparam int unsigned RES_MAX    = 5;    // results one character can cause
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = 3;

  // specifier states
  localparam logic [3:0] ST_LOOP    = 4'd0;
  localparam logic [3:0] ST_PCT     = 4'd1;
  localparam logic [3:0] ST_FLAGS   = 4'd2;
  localparam logic [3:0] ST_WIDTH   = 4'd3;
  localparam logic [3:0] ST_DOT     = 4'd4;
  localparam logic [3:0] ST_PREC    = 4'd5;
  localparam logic [3:0] ST_LEN     = 4'd6;
  localparam logic [3:0] ST_TYPE    = 4'd7;
  localparam logic [3:0] ST_OUTSIDE = 4'd9;

  // length modifiers
  localparam logic [2:0] MOD_NONE = 3'd0;
  localparam logic [2:0] MOD_H    = 3'd1;
  localparam logic [2:0] MOD_L    = 3'd2;
  localparam logic [2:0] MOD_BIGL = 3'd3;
  localparam logic [2:0] MOD_Z    = 3'd4;
  localparam logic [2:0] MOD_P    = 3'd5;

  // type codes
  localparam logic [3:0] TC_CHAR   = 4'd0;
  localparam logic [3:0] TC_INT32  = 4'd1;
  localparam logic [3:0] TC_SHORT  = 4'd2;
  localparam logic [3:0] TC_INT64  = 4'd3;
  localparam logic [3:0] TC_PTR    = 4'd4;
  localparam logic [3:0] TC_DOUBLE = 4'd5;
  localparam logic [3:0] TC_LDBL   = 4'd6;
  localparam logic [3:0] TC_PREC   = 4'd7;
  localparam logic [3:0] TC_STRING = 4'd8;

  // result kinds
  localparam logic KIND_CODE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // bit s set: state s may enter the indexed state
  localparam logic [15:0] ENTER_FROM [9] = '{
    16'h007D, 16'h0001, 16'h0007, 16'h000F, 16'h000F,
    16'h0030, 16'h002F, 16'h006F, 16'h0082
  };

  typedef struct packed {
    logic [3:0]       spec_state;
    logic [2:0]       length_mod;
    logic             star;
    logic [CNT_W-1:0] count;
    logic             failed;
    logic             held_vld;
    logic [7:0]       held_ch;
    logic             skip;
    logic             warn;
  } ctx_t;

  localparam ctx_t CTX_RESET = '{
    spec_state: ST_OUTSIDE, length_mod: MOD_NONE, star: 1'b0, count: '0,
    failed: 1'b0, held_vld: 1'b0, held_ch: 8'h00, skip: 1'b0, warn: 1'b0
  };

  typedef struct packed {
    logic             kind;
    logic [3:0]       type_code;
    logic [CNT_W-1:0] param_count;
    logic             ok;
    logic             warned;
    logic             eor;
  } res_t;

  typedef struct packed {
    ctx_t             ctx;
    logic [1:0]       n;
    logic [3:0]       code0;
    logic [CNT_W-1:0] cnt0;
    logic [3:0]       code1;
    logic [CNT_W-1:0] cnt1;
  } jud_t;

  function automatic logic may_enter(input logic [3:0] target, input logic [3:0] st);
    return ENTER_FROM[target][st];
  endfunction

  // count one parameter and record a type code
  function automatic jud_t add_code(input jud_t r, input logic [3:0] code);
    jud_t o;
    o = r;
    if (o.ctx.count != COUNT_MAX) o.ctx.count = o.ctx.count + 1'b1;
    if (o.n == 2'd0) begin
      o.code0 = code;
      o.cnt0  = o.ctx.count;
    end else begin
      o.code1 = code;
      o.cnt1  = o.ctx.count;
    end
    o.n = o.n + 2'd1;
    return o;
  endfunction

  // judge one template character with one character of lookahead
  function automatic jud_t fsc_judge(input ctx_t s, input logic [7:0] c,
                                     input logic [7:0] look, input logic wae);
    jud_t       r;
    logic       bad;
    logic [3:0] st;
    logic       look_digit;
    r          = '0;
    r.ctx      = s;
    bad        = 1'b0;
    st         = s.spec_state;
    look_digit = (look >= "0") && (look <= "9");
    if (s.skip) begin
      r.ctx.skip = 1'b0;
    end else if (s.failed) begin
      r.ctx = s;
    end else if (st == ST_OUTSIDE) begin
      if (c == "%") begin
        r.ctx.spec_state = ST_LOOP;
        r.ctx.length_mod = MOD_NONE;
        r.ctx.star       = 1'b0;
      end
    end else begin
      case (c) inside
        "%": begin
          if (may_enter(ST_PCT, st)) r.ctx.spec_state = ST_PCT;
          else bad = 1'b1;
        end
        "+", "-", " ", "#": begin
          if (!may_enter(ST_FLAGS, st)) bad = 1'b1;
          r.ctx.spec_state = ST_FLAGS;
        end
        "0": begin
          if (st == ST_WIDTH) begin
            bad = 1'b0;
          end else if (look == ".") begin
            if (!may_enter(ST_WIDTH, st)) bad = 1'b1;
            r.ctx.spec_state = ST_WIDTH;
          end else if (look_digit) begin
            if (!may_enter(ST_FLAGS, st)) bad = 1'b1;
            r.ctx.spec_state = ST_FLAGS;
          end else if (st == ST_PREC) begin
            bad = 1'b0;
          end else if (!may_enter(ST_FLAGS, st)) begin
            bad = 1'b1;
          end
        end
        "*", ["1":"9"]: begin
          if (may_enter(ST_WIDTH, st)) begin
            r.ctx.spec_state = ST_WIDTH;
          end else if (may_enter(ST_PREC, st)) begin
            r.ctx.spec_state = ST_PREC;
            if (c == "*") r.ctx.star = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end
        ".": begin
          if (!may_enter(ST_DOT, st)) bad = 1'b1;
          r.ctx.spec_state = ST_PREC;
        end
        "h", "L", "z", "P", "l": begin
          if (!may_enter(ST_LEN, st)) begin
            bad = 1'b1;
          end else begin
            r.ctx.spec_state = ST_LEN;
            case (c)
              "h":     r.ctx.length_mod = MOD_H;
              "L":     r.ctx.length_mod = MOD_BIGL;
              "z":     r.ctx.length_mod = MOD_Z;
              "P":     r.ctx.length_mod = MOD_P;
              default: r.ctx.length_mod = MOD_L;
            endcase
            if (c == "l") begin
              if (look == "l") begin
                r.ctx.skip = 1'b1;
              end else if (look == "d" || look == "i" || look == "x" ||
                           look == "X" || look == "u") begin
                if (wae) bad = 1'b1;
                else r.ctx.warn = 1'b1;
              end
            end
          end
        end
        "c", "d", "e", "E", "f", "g", "G", "i", "o", "p", "x", "X", "u", "J", "s": begin
          if (c != "s" && s.star) begin
            bad = 1'b1;
          end else begin
            if (!may_enter(ST_TYPE, st)) bad = 1'b1;
            case (c) inside
              "c":      r = add_code(r, TC_CHAR);
              "p", "J": r = add_code(r, TC_PTR);
              "s": begin
                if (s.star) r = add_code(r, TC_PREC);
                r = add_code(r, TC_STRING);
              end
              "e", "E", "f", "g", "G": begin
                if (s.length_mod == MOD_NONE) begin
                  r = add_code(r, TC_DOUBLE);
                end else if (s.length_mod == MOD_BIGL) begin
                  r = add_code(r, TC_LDBL);
                end else begin
                  // counted, but no code and the template fails
                  if (r.ctx.count != COUNT_MAX) r.ctx.count = r.ctx.count + 1'b1;
                  bad = 1'b1;
                end
              end
              default: begin
                case (s.length_mod)
                  MOD_NONE:         r = add_code(r, TC_INT32);
                  MOD_H:            r = add_code(r, TC_SHORT);
                  MOD_L, MOD_BIGL:  r = add_code(r, TC_INT64);
                  default:          r = add_code(r, TC_PTR);
                endcase
              end
            endcase
            r.ctx.spec_state = ST_TYPE;
          end
        end
        default: bad = 1'b1;
      endcase
      if (bad) begin
        r.ctx.failed = 1'b1;
      end else if (r.ctx.spec_state == ST_PCT || r.ctx.spec_state == ST_TYPE) begin
        r.ctx.spec_state = ST_OUTSIDE;
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/format_specifier_checker_top.sv */
// ----------------------------------------------------------------------------
// format_specifier_checker_top
// Streaming checker for printf-style templates with type-code output.
// ----------------------------------------------------------------------------
// Feed the template one character per transaction, with last_i set on the
// final character. Each character is registered and held, then judged once
// the following character is registered (one character of lookahead); the
// block takes one character per clock when results keep draining. A
// conversion produces one type-code transaction ('%.*s' produces two: the
// precision and then the string), and the final character always adds one
// status transaction carrying ok, the warning mark and the parameter count;
// end_of_run_o flags the last result caused by a character. Results wait in
// an 8-entry queue and leave one per cycle while out_stall_i is low; a
// character that causes up to five results is taken only when the queue has
// room for all of them, and the input stalls otherwise. warn_as_error is
// written through cfg_we_i and must only change between templates while the
// block is idle.
// ----------------------------------------------------------------------------
module format_specifier_checker_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  // character input
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                ch_i,
  input  logic                      last_i,
  // result output
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      kind_o,
  output logic [3:0]                type_code_o,
  output logic [fsc_pkg::CNT_W-1:0] param_count_o,
  output logic                      ok_o,
  output logic                      warned_o,
  output logic                      end_of_run_o
);

  // warn_as_error register
  logic wae_q;

  // input register
  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       last_q;
  logic       in_accept;

  // template context
  fsc_pkg::ctx_t ctx_q;
  fsc_pkg::ctx_t ctx_d;

  // step results
  fsc_pkg::res_t [fsc_pkg::RES_MAX-1:0] step_res;
  logic [2:0]                           step_n;
  logic                                 consume;

  // result queue
  fsc_pkg::res_t              fifo_q [fsc_pkg::FIFO_DEPTH];
  logic [fsc_pkg::FIFO_AW-1:0] wr_ptr_q;
  logic [fsc_pkg::FIFO_AW-1:0] rd_ptr_q;
  logic [fsc_pkg::FIFO_AW:0]   cnt_q;
  logic [fsc_pkg::FIFO_AW:0]   cnt_d;
  logic [fsc_pkg::FIFO_AW:0]   push_n;
  logic                        pop;
  fsc_pkg::res_t               head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wae_q <= 1'b0;
    end else if (cfg_we_i) begin
      wae_q <= cfg_wdata_i;
    end
  end

  fsc_step u_step (
    .ctx_i  (ctx_q),
    .ch_i   (ch_q),
    .last_i (last_q),
    .wae_i  (wae_q),
    .ctx_o  (ctx_d),
    .res_o  (step_res),
    .n_o    (step_n)
  );

  // Take the registered character only when all its results fit. The pop of
  // this cycle is not counted, which keeps out_stall_i off the input path.
  assign consume = in_valid_q &&
                   ({2'b00, step_n} + {1'b0, cnt_q} <= (fsc_pkg::FIFO_AW + 2)'(fsc_pkg::FIFO_DEPTH));

  assign in_stall_o = in_valid_q && !consume;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      ctx_q      <= fsc_pkg::CTX_RESET;
    end else begin
      if (in_accept) in_valid_q <= 1'b1;
      else if (consume) in_valid_q <= 1'b0;
      if (consume) ctx_q <= ctx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
  end

  // result queue
  assign head   = fifo_q[rd_ptr_q];
  assign pop    = out_valid_o && !out_stall_i;
  assign push_n = consume ? {1'b0, step_n} : '0;
  assign cnt_d  = cnt_q + push_n - {{fsc_pkg::FIFO_AW{1'b0}}, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n[fsc_pkg::FIFO_AW-1:0];
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < fsc_pkg::RES_MAX; k++) begin
      if (consume && 3'(k) < step_n) begin
        fifo_q[wr_ptr_q + fsc_pkg::FIFO_AW'(k)] <= step_res[k];
      end
    end
  end

  assign out_valid_o   = (cnt_q != '0);
  assign kind_o        = head.kind;
  assign type_code_o   = head.type_code;
  assign param_count_o = head.param_count;
  assign ok_o          = head.ok;
  assign warned_o      = head.warned;
  assign end_of_run_o  = head.eor;

  // queue never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (fsc_pkg::FIFO_AW + 1)'(fsc_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // every final character yields at least its status result
  a_last_has_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && last_q) |-> (step_n != 3'd0))
    else $error("final character without status");

  // after a final character the template context is back at reset
  a_ctx_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && last_q) |=> (ctx_q == fsc_pkg::CTX_RESET))
    else $error("context not cleared after template end");

  // the specifier state never leaves its legal range
  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctx_q.spec_state <= fsc_pkg::ST_TYPE) || (ctx_q.spec_state == fsc_pkg::ST_OUTSIDE))
    else $error("specifier state out of range");

endmodule

/* hw/rtl/fsc_step.sv */
// ----------------------------------------------------------------------------
// fsc_step
// Combinational step for one character: judges the held character, then on
// the final character judges it too and builds the status result.
// ----------------------------------------------------------------------------
module fsc_step (
  input  fsc_pkg::ctx_t                            ctx_i,
  input  logic [7:0]                               ch_i,
  input  logic                                     last_i,
  input  logic                                     wae_i,
  output fsc_pkg::ctx_t                            ctx_o,
  output fsc_pkg::res_t [fsc_pkg::RES_MAX-1:0]     res_o,
  output logic [2:0]                               n_o
);

  fsc_pkg::jud_t                        j1;
  fsc_pkg::jud_t                        j2;
  fsc_pkg::ctx_t                        s;
  fsc_pkg::ctx_t                        s_mid;
  fsc_pkg::res_t [fsc_pkg::RES_MAX-1:0] res;
  logic [2:0]                           n;

  assign j1 = fsc_pkg::fsc_judge(ctx_i, ctx_i.held_ch, ch_i, wae_i);

  always_comb begin
    s_mid = ctx_i;
    if (ctx_i.held_vld) s_mid = j1.ctx;
    s_mid.held_vld = 1'b1;
    s_mid.held_ch  = ch_i;
  end

  // final character sees a NUL lookahead
  assign j2 = fsc_pkg::fsc_judge(s_mid, ch_i, 8'h00, wae_i);

  always_comb begin
    res = '0;
    n   = 3'd0;
    s   = s_mid;
    if (ctx_i.held_vld && j1.n != 2'd0) begin
      res[n] = '{kind: fsc_pkg::KIND_CODE, type_code: j1.code0, param_count: j1.cnt0,
                 ok: 1'b0, warned: 1'b0, eor: 1'b0};
      n = n + 3'd1;
      if (j1.n == 2'd2) begin
        res[n] = '{kind: fsc_pkg::KIND_CODE, type_code: j1.code1, param_count: j1.cnt1,
                   ok: 1'b0, warned: 1'b0, eor: 1'b0};
        n = n + 3'd1;
      end
    end
    if (last_i) begin
      s = j2.ctx;
      if (j2.n != 2'd0) begin
        res[n] = '{kind: fsc_pkg::KIND_CODE, type_code: j2.code0, param_count: j2.cnt0,
                   ok: 1'b0, warned: 1'b0, eor: 1'b0};
        n = n + 3'd1;
        if (j2.n == 2'd2) begin
          res[n] = '{kind: fsc_pkg::KIND_CODE, type_code: j2.code1, param_count: j2.cnt1,
                     ok: 1'b0, warned: 1'b0, eor: 1'b0};
          n = n + 3'd1;
        end
      end
      if (!s.failed && s.spec_state != fsc_pkg::ST_OUTSIDE) s.failed = 1'b1;
      res[n] = '{kind: fsc_pkg::KIND_STATUS, type_code: fsc_pkg::TC_CHAR,
                 param_count: s.count, ok: !s.failed, warned: s.warn, eor: 1'b0};
      n = n + 3'd1;
      s = fsc_pkg::CTX_RESET;
    end
    for (int k = 0; k < fsc_pkg::RES_MAX; k++) begin
      if (n != 3'd0 && 3'(k) == n - 3'd1) res[k].eor = 1'b1;
    end
  end

  assign ctx_o = s;
  assign res_o = res;
  assign n_o   = n;

endmodule

/* tb/sv/fsc_result_watch.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fsc_result_watch
// Watches the character and result channels of the format checker, predicts
// the type-code and status transactions and compares them field by field.
// ----------------------------------------------------------------------------
module fsc_result_watch (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [7:0]                ch_i,
  input  logic                      last_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic                      kind_i,
  input  logic [3:0]                type_code_i,
  input  logic [fsc_pkg::CNT_W-1:0] param_count_i,
  input  logic                      ok_i,
  input  logic                      warned_i,
  input  logic                      end_of_run_i,
  output int unsigned               err_count_o,
  output int unsigned               pending_o
);

  // bit s set: state s may step into the indexed state
  localparam logic [15:0] ENTRY_MASK [9] = '{
    16'h007D, 16'h0001, 16'h0007, 16'h000F, 16'h000F,
    16'h0030, 16'h002F, 16'h006F, 16'h0082
  };

  // own copy of the block state
  logic                      warn_is_error;
  logic [3:0]                spec_st;
  logic [2:0]                len_mod;
  logic                      star_prec;
  logic [fsc_pkg::CNT_W-1:0] params_seen;
  logic                      tmpl_failed;
  logic                      held_vld;
  logic [7:0]                held_ch;
  logic                      skip_next;
  logic                      warn_mark;

  fsc_pkg::res_t char_results[$];    // results of the character being judged
  fsc_pkg::res_t expected_results[$];
  int unsigned   errors;

  function automatic logic may_enter(input logic [3:0] target);
    return ENTRY_MASK[target][spec_st];
  endfunction

  task automatic count_param();
    if (params_seen != fsc_pkg::COUNT_MAX) params_seen = params_seen + 1'b1;
  endtask

  task automatic add_result(input logic kind, input logic [3:0] code,
                            input logic ok, input logic warned);
    fsc_pkg::res_t r;
    r             = '0;
    r.kind        = kind;
    r.type_code   = code;
    r.param_count = params_seen;
    r.ok          = ok;
    r.warned      = warned;
    char_results.push_back(r);
  endtask

  task automatic emit_code(input logic [3:0] code);
    count_param();
    add_result(fsc_pkg::KIND_CODE, code, 1'b0, 1'b0);
  endtask

  task automatic clear_template();
    spec_st     = fsc_pkg::ST_OUTSIDE;
    len_mod     = fsc_pkg::MOD_NONE;
    star_prec   = 1'b0;
    params_seen = '0;
    tmpl_failed = 1'b0;
    held_vld    = 1'b0;
    held_ch     = 8'h00;
    skip_next   = 1'b0;
    warn_mark   = 1'b0;
  endtask

  // judge one template character against the one after it
  task automatic judge_char(input logic [7:0] c, input logic [7:0] look);
    logic bad;
    bad = 1'b0;
    if (skip_next) begin
      skip_next = 1'b0;
      return;
    end
    if (tmpl_failed) return;
    if (spec_st == fsc_pkg::ST_OUTSIDE) begin
      if (c == "%") begin
        spec_st   = fsc_pkg::ST_LOOP;
        len_mod   = fsc_pkg::MOD_NONE;
        star_prec = 1'b0;
      end
      return;
    end
    case (c)
      "%": begin
        if (may_enter(fsc_pkg::ST_PCT)) spec_st = fsc_pkg::ST_PCT;
        else bad = 1'b1;
      end
      "+", "-", " ", "#": begin
        if (!may_enter(fsc_pkg::ST_FLAGS)) bad = 1'b1;
        spec_st = fsc_pkg::ST_FLAGS;
      end
      "0": begin
        if (spec_st == fsc_pkg::ST_WIDTH) begin
          bad = 1'b0;
        end else if (look == ".") begin
          if (!may_enter(fsc_pkg::ST_WIDTH)) bad = 1'b1;
          spec_st = fsc_pkg::ST_WIDTH;
        end else if (look >= "0" && look <= "9") begin
          if (!may_enter(fsc_pkg::ST_FLAGS)) bad = 1'b1;
          spec_st = fsc_pkg::ST_FLAGS;
        end else if (spec_st == fsc_pkg::ST_PREC) begin
          bad = 1'b0;
        end else if (!may_enter(fsc_pkg::ST_FLAGS)) begin
          bad = 1'b1;
        end
      end
      "*", "1", "2", "3", "4", "5", "6", "7", "8", "9": begin
        if (may_enter(fsc_pkg::ST_WIDTH)) begin
          spec_st = fsc_pkg::ST_WIDTH;
        end else if (may_enter(fsc_pkg::ST_PREC)) begin
          spec_st = fsc_pkg::ST_PREC;
          if (c == "*") star_prec = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      ".": begin
        if (!may_enter(fsc_pkg::ST_DOT)) bad = 1'b1;
        spec_st = fsc_pkg::ST_PREC;
      end
      "h", "L", "z", "P", "l": begin
        if (!may_enter(fsc_pkg::ST_LEN)) begin
          bad = 1'b1;
        end else begin
          spec_st = fsc_pkg::ST_LEN;
          case (c)
            "h":     len_mod = fsc_pkg::MOD_H;
            "L":     len_mod = fsc_pkg::MOD_BIGL;
            "z":     len_mod = fsc_pkg::MOD_Z;
            "P":     len_mod = fsc_pkg::MOD_P;
            default: len_mod = fsc_pkg::MOD_L;
          endcase
          if (c == "l") begin
            if (look == "l") begin
              skip_next = 1'b1;
            end else if (look == "d" || look == "i" || look == "x" ||
                         look == "X" || look == "u") begin
              if (warn_is_error) bad = 1'b1;
              else warn_mark = 1'b1;
            end
          end
        end
      end
      "c", "d", "e", "E", "f", "g", "G", "i", "o", "p", "x", "X", "u", "J", "s": begin
        if (c != "s" && star_prec) begin
          bad = 1'b1;
        end else begin
          // a type reached from a bad state still emits, then fails
          if (!may_enter(fsc_pkg::ST_TYPE)) bad = 1'b1;
          case (c)
            "c":      emit_code(fsc_pkg::TC_CHAR);
            "p", "J": emit_code(fsc_pkg::TC_PTR);
            "s": begin
              if (star_prec) emit_code(fsc_pkg::TC_PREC);
              emit_code(fsc_pkg::TC_STRING);
            end
            "e", "E", "f", "g", "G": begin
              if (len_mod == fsc_pkg::MOD_NONE) begin
                emit_code(fsc_pkg::TC_DOUBLE);
              end else if (len_mod == fsc_pkg::MOD_BIGL) begin
                emit_code(fsc_pkg::TC_LDBL);
              end else begin
                count_param();
                bad = 1'b1;
              end
            end
            default: begin
              case (len_mod)
                fsc_pkg::MOD_NONE:                  emit_code(fsc_pkg::TC_INT32);
                fsc_pkg::MOD_H:                     emit_code(fsc_pkg::TC_SHORT);
                fsc_pkg::MOD_L, fsc_pkg::MOD_BIGL:  emit_code(fsc_pkg::TC_INT64);
                default:                            emit_code(fsc_pkg::TC_PTR);
              endcase
            end
          endcase
          spec_st = fsc_pkg::ST_TYPE;
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      tmpl_failed = 1'b1;
    end else if (spec_st == fsc_pkg::ST_PCT || spec_st == fsc_pkg::ST_TYPE) begin
      spec_st = fsc_pkg::ST_OUTSIDE;
    end
  endtask

  // one accepted character: judge the held one, hold this one
  task automatic predict_char(input logic [7:0] c, input logic is_last);
    fsc_pkg::res_t r;
    char_results.delete();
    if (held_vld) judge_char(held_ch, c);
    held_vld = 1'b1;
    held_ch  = c;
    if (is_last) begin
      judge_char(c, 8'h00);
      if (!tmpl_failed && spec_st != fsc_pkg::ST_OUTSIDE) tmpl_failed = 1'b1;
      add_result(fsc_pkg::KIND_STATUS, fsc_pkg::TC_CHAR, !tmpl_failed, warn_mark);
      clear_template();
    end
    foreach (char_results[i]) begin
      r     = char_results[i];
      r.eor = (i == char_results.size() - 1);
      expected_results.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: result mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_result();
    fsc_pkg::res_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result transaction with nothing expected");
      return;
    end
    want = expected_results.pop_front();
    if (kind_i != want.kind)
      report_mismatch($sformatf("kind got %0d want %0d", kind_i, want.kind));
    if (type_code_i != want.type_code)
      report_mismatch($sformatf("type_code got %0d want %0d", type_code_i,
                                want.type_code));
    if (param_count_i != want.param_count)
      report_mismatch($sformatf("param_count got %0d want %0d", param_count_i,
                                want.param_count));
    if (ok_i != want.ok)
      report_mismatch($sformatf("ok got %0d want %0d", ok_i, want.ok));
    if (warned_i != want.warned)
      report_mismatch($sformatf("warned got %0d want %0d", warned_i, want.warned));
    if (end_of_run_i != want.eor)
      report_mismatch($sformatf("end_of_run got %0d want %0d", end_of_run_i,
                                want.eor));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_is_error = 1'b0;
      clear_template();
      expected_results.delete();
      errors = 0;
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      // results cannot stem from a character taken at the same edge
      if (out_valid_i && !out_stall_i) check_result();
      if (cfg_we_i) warn_is_error = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) predict_char(ch_i, last_i);
      err_count_o <= errors;
      pending_o   <= unsigned'(expected_results.size());
    end
  end

endmodule

/* tb/sv/tb_format_specifier_checker_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_format_specifier_checker_top
// Streams printf-style templates into the format checker and judges the run.
// ----------------------------------------------------------------------------
// A short directed set covers the odd corners (star precision with a string,
// stray NUL and 0xFF bytes, double and triple l, template ending inside a
// specifier, star width, float with a bad length, the l warning as error).
// The bulk is random templates: mostly well-formed specifiers with random
// flags, width, precision, length and type, plus broken and noise templates,
// and one long template that drives the parameter count into saturation.
// fsc_result_watch predicts and compares; this module only drives and decides.
// ----------------------------------------------------------------------------
module tb_format_specifier_checker_top;

  // DUT inputs, all known from time zero
  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic cfg_we_i    = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic in_valid_i  = 1'b0;
  logic [7:0] ch_i  = 8'h00;
  logic last_i      = 1'b0;
  logic out_stall_i = 1'b0;

  // DUT outputs
  logic                      in_stall_o;
  logic                      out_valid_o;
  logic                      kind_o;
  logic [3:0]                type_code_o;
  logic [fsc_pkg::CNT_W-1:0] param_count_o;
  logic                      ok_o;
  logic                      warned_o;
  logic                      end_of_run_o;

  int unsigned err_count;
  int unsigned pending;

  // traffic shaping
  logic        calm       = 1'b0;  // no random idling on either side while set
  int unsigned hold_reqs  = 0;     // long receiver hold-offs asked for
  int unsigned holds_done = 0;
  int unsigned hold_left  = 0;

  logic [7:0]  tmpl[$];            // template being built
  int unsigned chars_sent = 0;

  string FLAG_CHARS = "+- #0";
  string TYPE_CHARS = "cdeEfgGioxXuJsp%";

  format_specifier_checker_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .ch_i          (ch_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .type_code_o   (type_code_o),
    .param_count_o (param_count_o),
    .ok_o          (ok_o),
    .warned_o      (warned_o),
    .end_of_run_o  (end_of_run_o)
  );

  fsc_result_watch watch (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .ch_i          (ch_i),
    .last_i        (last_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_i        (kind_o),
    .type_code_i   (type_code_o),
    .param_count_i (param_count_o),
    .ok_i          (ok_o),
    .warned_i      (warned_o),
    .end_of_run_i  (end_of_run_o),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard stop; far beyond the slowest legal run (~650 characters)
  initial begin
    #5_000_000;
    $display("[format_specifier_checker_top] ERROR");
    $finish;
  end

  // receiver: random stalls, plus long hold-offs on request so that the
  // 8-entry result queue fills and the block stalls its input
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_reqs != holds_done) begin
        holds_done++;
        hold_left = 80;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 25);
      end
    end
  end

  // one character transaction; valid idles at random in front of it
  task automatic send_char(input logic [7:0] c, input logic is_last);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    last_i     <= is_last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) tmpl.push_back(s[i]);
  endtask

  // send the built template, last set on its final character
  task automatic send_tmpl();
    foreach (tmpl[i]) send_char(tmpl[i], i == tmpl.size() - 1);
    tmpl.delete();
  endtask

  // drain by waiting until every expected result is back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_warn_mode(input logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // random conversion: flags, width, precision, length, type
  task automatic add_specifier();
    tmpl.push_back("%");
    repeat ($urandom_range(0, 2)) tmpl.push_back(FLAG_CHARS[$urandom_range(0, 4)]);
    case ($urandom_range(0, 3))
      1: begin
        tmpl.push_back(8'($urandom_range("1", "9")));
        if ($urandom_range(0, 1)) tmpl.push_back(8'($urandom_range("0", "9")));
      end
      2: tmpl.push_back("*");
      3: tmpl.push_back("0");
      default: ;
    endcase
    if ($urandom_range(0, 1)) begin
      tmpl.push_back(".");
      case ($urandom_range(0, 2))
        1: begin
          tmpl.push_back(8'($urandom_range("0", "9")));
          if ($urandom_range(0, 1)) tmpl.push_back(8'($urandom_range("0", "9")));
        end
        2: tmpl.push_back("*");
        default: ;
      endcase
    end
    case ($urandom_range(0, 9))
      1: tmpl.push_back("h");
      2: tmpl.push_back("l");
      3: add_str("ll");
      4: tmpl.push_back("L");
      5: tmpl.push_back("z");
      6: tmpl.push_back("P");
      7: add_str("lll");
      default: ;
    endcase
    tmpl.push_back(TYPE_CHARS[$urandom_range(0, TYPE_CHARS.len() - 1)]);
  endtask

  // mostly well-formed templates with random content; some broken, some noise
  task automatic build_template();
    int unsigned mode;
    int unsigned pos;
    mode = $urandom_range(0, 9);
    tmpl.delete();
    if (mode == 0) begin
      repeat ($urandom_range(1, 12)) tmpl.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) < 4) begin
          repeat ($urandom_range(1, 4)) tmpl.push_back(8'($urandom_range(32, 126)));
        end else begin
          add_specifier();
        end
      end
      if (mode == 1) begin
        // corrupt one byte, or cut the template short
        pos = $urandom_range(0, tmpl.size() - 1);
        if ($urandom_range(0, 1)) tmpl[pos] = 8'($urandom_range(0, 255));
        else while (tmpl.size() > pos + 1) void'(tmpl.pop_back());
      end
    end
  endtask

  task automatic run_random(input int unsigned upto);
    while (chars_sent < upto) begin
      build_template();
      send_tmpl();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed templates, l rule as a warning
    write_warn_mode(1'b0);
    add_str("%.*s");                 // precision code, then string code
    send_tmpl();
    tmpl.push_back(8'hFF);           // stray top byte and NUL outside specifier
    tmpl.push_back(8'h00);
    add_str("%ld");                  // single l before d: warning mark
    send_tmpl();
    add_str("%lld%");                // double l, then ends inside a specifier
    send_tmpl();
    add_str("%*hf");                 // star width, float with bad length
    send_tmpl();
    tmpl.push_back("%");             // NUL inside a specifier
    tmpl.push_back(8'h00);
    send_tmpl();
    add_str("%lllx");                // third l fails
    send_tmpl();
    wait_idle();

    // l rule as a hard failure
    write_warn_mode(1'b1);
    add_str("%lx");
    send_tmpl();
    run_random(chars_sent + 40);
    wait_idle();

    // back to warnings, random traffic with idling on both sides
    write_warn_mode(1'b0);
    run_random(chars_sent + 30);

    // long hold-off first, then one long template with no idling that
    // also drives the parameter count into saturation
    hold_reqs++;
    calm = 1'b1;
    repeat (256) add_str("%c");
    send_tmpl();
    calm = 1'b0;
    wait_idle();
    repeat (10) @(posedge clk_i);

    if (err_count == 0 && pending == 0) begin
      $display("[format_specifier_checker_top] OK");
    end else begin
      $display("[format_specifier_checker_top] ERROR");
    end
    $finish;
  end

endmodule

/* format_specifier_checker_top.f */
hw/rtl/fsc_pkg.sv
hw/rtl/fsc_step.sv
hw/rtl/format_specifier_checker_top.sv
tb/sv/fsc_result_watch.sv
tb/sv/tb_format_specifier_checker_top.sv
